@@ design/art_pkg.sv @@
// ----------------------------------------------------------------------------
// Address region table package
// Shared action and status codes.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_BAD_RANGE = 3'd2;
    localparam logic [2:0] ST_OVERLAP   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

endpackage

@@ design/art_front.sv @@
// ----------------------------------------------------------------------------
// Address region table front end
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module art_front #(
    parameter int ADDR_BITS = 39
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [ADDR_BITS-1:0] i_region_start,
    input  logic [ADDR_BITS-1:0] i_region_end,
    input  logic [2:0]           i_region_flags,
    input  logic [ADDR_BITS-1:0] i_lookup_addr,
    output logic                 o_q_valid,
    input  logic                 i_q_take,
    output logic [1:0]           o_q_action,
    output logic                 o_q_bad,
    output logic [ADDR_BITS-1:0] o_q_start,
    output logic [ADDR_BITS-1:0] o_q_end,
    output logic [2:0]           o_q_flags
);
    import art_pkg::*;

    logic [1:0]           r_act [2];
    logic                 r_bad [2];
    logic [ADDR_BITS-1:0] r_s [2];
    logic [ADDR_BITS-1:0] r_e [2];
    logic [2:0]           r_f [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_q_take && (r_cnt != 2'd0);

    // Store the beat; a lookup carries its address in the start slot.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_act[r_wp] <= i_action;
            r_bad[r_wp] <= !(i_region_start < i_region_end);
            r_s[r_wp]   <= (i_action == ACT_LOOKUP) ? i_lookup_addr : i_region_start;
            r_e[r_wp]   <= i_region_end;
            r_f[r_wp]   <= i_region_flags;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_action = r_act[r_rp];
    assign o_q_bad    = r_bad[r_rp];
    assign o_q_start  = r_s[r_rp];
    assign o_q_end    = r_e[r_rp];
    assign o_q_flags  = r_f[r_rp];

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop)
        else $error("pop from empty queue");
`endif
endmodule

@@ design/art_back.sv @@
// ----------------------------------------------------------------------------
// Address region table back end
// Takes one item at a time; walks the sorted table to look up or insert, or clears.
// ----------------------------------------------------------------------------
module art_back #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 39
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_take,
    input  logic [1:0]           i_q_action,
    input  logic                 i_q_bad,
    input  logic [ADDR_BITS-1:0] i_q_start,
    input  logic [ADDR_BITS-1:0] i_q_end,
    input  logic [2:0]           i_q_flags,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic [ADDR_BITS-1:0] o_hit_start,
    output logic [ADDR_BITS-1:0] o_hit_end,
    output logic [2:0]           o_hit_flags,
    output logic                 o_cache_hit,
    output logic [6:0]           o_region_count
);
    import art_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SHRD  = 3'd3;
    localparam logic [2:0] S_SHWR  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [ADDR_BITS-1:0] m_s [MAX_REGIONS];
    logic [ADDR_BITS-1:0] m_e [MAX_REGIONS];
    logic [2:0]           m_f [MAX_REGIONS];

    logic [2:0]           r_state;
    logic [CW-1:0]        r_count, r_idx;
    logic [CW-1:0]        r_slot;
    logic [1:0]           r_act;
    logic [ADDR_BITS-1:0] r_a, r_b;
    logic [2:0]           r_fl;
    logic [ADDR_BITS-1:0] r_rs, r_re, r_prev_e;
    logic [2:0]           r_rf;
    logic                 r_has_prev;
    logic                 r_lv;
    logic [ADDR_BITS-1:0] r_ls, r_le;
    logic [2:0]           r_lf;
    logic                 r_ov;
    logic [2:0]           r_ost;
    logic [ADDR_BITS-1:0] r_ohs, r_ohe;
    logic [2:0]           r_ohf;
    logic                 r_och;
    logic                 r_wen;
    logic [IW-1:0]        r_wa, r_ra;
    logic [ADDR_BITS-1:0] r_ws, r_we;
    logic [2:0]           r_wf;

    assign o_q_take = (r_state == S_IDLE) && !r_ov;

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (r_wen) begin
            m_s[r_wa] <= r_ws;
            m_e[r_wa] <= r_we;
            m_f[r_wa] <= r_wf;
        end
        r_rs <= m_s[r_ra];
        r_re <= m_e[r_ra];
        r_rf <= m_f[r_ra];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lv <= 1'b0;
            r_ls <= '0;
            r_le <= '0;
            r_lf <= '0;
            r_ov <= 1'b0;
            r_wen <= 1'b0;
        end else begin
            r_wen <= (r_state == S_SHWR);
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !r_ov) begin
                        r_act <= i_q_action;
                        r_a <= i_q_start;
                        r_b <= i_q_end;
                        r_fl <= i_q_flags;
                        r_ohs <= '0;
                        r_ohe <= '0;
                        r_ohf <= '0;
                        r_och <= 1'b0;
                        r_ost <= ST_OK;
                        r_idx <= '0;
                        r_ra <= '0;
                        r_has_prev <= 1'b0;
                        case (i_q_action)
                            ACT_INSERT: begin
                                if (i_q_bad) begin
                                    r_ost <= ST_BAD_RANGE;
                                    r_state <= S_OUT;
                                end else if (r_count == '0) begin
                                    r_state <= S_CHK;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            ACT_LOOKUP: begin
                                if (r_lv && r_ls <= i_q_start && i_q_start < r_le) begin
                                    r_ohs <= r_ls;
                                    r_ohe <= r_le;
                                    r_ohf <= r_lf;
                                    r_och <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_ost <= ST_NOT_FOUND;
                                    r_state <= (r_count == '0) ? S_OUT : S_RD;
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_lv <= 1'b0;
                                r_ls <= '0;
                                r_le <= '0;
                                r_lf <= '0;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                // Read latency slot; data for r_idx is valid next cycle.
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_act == ACT_LOOKUP) begin
                        if (r_rs <= r_a && r_a < r_re) begin
                            r_ohs <= r_rs;
                            r_ohe <= r_re;
                            r_ohf <= r_rf;
                            r_ost <= ST_OK;
                            r_lv <= 1'b1;
                            r_ls <= r_rs;
                            r_le <= r_re;
                            r_lf <= r_rf;
                            r_state <= S_OUT;
                        end else if (r_idx + 1'b1 == r_count) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_ra <= IW'(r_idx + 1'b1);
                            r_state <= S_RD;
                        end
                    end else if (r_idx < r_count && r_rs <= r_a) begin
                        // Entry goes before the new one; keep walking.
                        r_prev_e <= r_re;
                        r_has_prev <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_ra <= IW'(r_idx + 1'b1);
                        r_state <= (r_idx + 1'b1 == r_count) ? S_CHK : S_RD;
                    end else begin
                        // r_idx is the slot.
                        if ((r_has_prev && r_prev_e > r_a) ||
                            (r_idx < r_count && r_b > r_rs)) begin
                            r_ost <= ST_OVERLAP;
                            r_state <= S_OUT;
                        end else if (r_count >= MAXC) begin
                            r_ost <= ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            // Shift from the top down to the slot.
                            r_idx <= r_count;
                            r_ra <= IW'(r_count - 1'b1);
                            r_state <= S_SHRD;
                        end
                    end
                end
                S_SHRD: begin
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    r_wa <= IW'(r_idx);
                    if (r_idx == '0 || r_idx == r_slot) begin
                        r_ws <= r_a;
                        r_we <= r_b;
                        r_wf <= r_fl;
                        r_count <= r_count + 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_ws <= r_rs;
                        r_we <= r_re;
                        r_wf <= r_rf;
                        r_idx <= r_idx - 1'b1;
                        r_ra <= IW'(r_idx - 2'd2);
                        r_state <= S_SHRD;
                    end
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Insert slot: kept while shifting.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK && r_act == ACT_INSERT) r_slot <= r_idx;
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_hit_start    = r_ohs;
    assign o_hit_end      = r_ohe;
    assign o_hit_flags    = r_ohf;
    assign o_cache_hit    = r_och;
    assign o_region_count = 7'(r_count);

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= MAXC)
        else $error("region count beyond depth");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov && $stable(r_ost))
        else $error("stalled result changed");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |-> !r_ov)
        else $error("took work while result pending");
`endif
endmodule

@@ design/address_region_table_core.sv @@
// ----------------------------------------------------------------------------
// Address region table core
// Sorted region table with last-hit copy; front queue plus walking back end.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// input   | i_valid / o_stall  | action, region_start/end/flags, lookup_addr
// output  | o_valid / i_stall  | status, hit_start/end/flags, cache_hit, count
//
// Lookup walks the table entry by entry, reading and then checking each one.
// Insert walks to the slot and then shifts entries down, reading and then writing
// each one; clear and cache hits skip the walk.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled result holds the back end; the front queue keeps two items.
module address_region_table_core #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 39
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [ADDR_BITS-1:0] i_region_start,
    input  logic [ADDR_BITS-1:0] i_region_end,
    input  logic [2:0]           i_region_flags,
    input  logic [ADDR_BITS-1:0] i_lookup_addr,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic [ADDR_BITS-1:0] o_hit_start,
    output logic [ADDR_BITS-1:0] o_hit_end,
    output logic [2:0]           o_hit_flags,
    output logic                 o_cache_hit,
    output logic [6:0]           o_region_count
);
    logic                 w_qv, w_take, w_bad;
    logic [1:0]           w_act;
    logic [ADDR_BITS-1:0] w_s, w_e;
    logic [2:0]           w_f;

    // Front end with queue.
    art_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_region_start(i_region_start),
        .i_region_end(i_region_end), .i_region_flags(i_region_flags),
        .i_lookup_addr(i_lookup_addr), .o_q_valid(w_qv), .i_q_take(w_take),
        .o_q_action(w_act), .o_q_bad(w_bad), .o_q_start(w_s), .o_q_end(w_e),
        .o_q_flags(w_f)
    );

    // Back end sequencer and table.
    art_back #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_take(w_take),
        .i_q_action(w_act), .i_q_bad(w_bad), .i_q_start(w_s), .i_q_end(w_e),
        .i_q_flags(w_f), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_hit_start(o_hit_start), .o_hit_end(o_hit_end),
        .o_hit_flags(o_hit_flags), .o_cache_hit(o_cache_hit),
        .o_region_count(o_region_count)
    );
endmodule
